// ===== rtl/iebm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iebm_pkg
// Shared types and constants for the I2C EEPROM byte master.
// ----------------------------------------------------------------------------
package iebm_pkg;

  localparam int PHASE_W     = 16;
  localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd100;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] dev_addr;
    logic [7:0] memory_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic scl;
    logic drv;
    logic lvl;
  } pins_t;

endpackage : iebm_pkg
`default_nettype wire

// ===== rtl/iebm_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iebm_ifs
// Request and result channels of the I2C EEPROM byte master.
// ----------------------------------------------------------------------------
interface iebm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] dev_addr;
  logic [7:0] memory_address;
  logic [7:0] write_data;
  logic       sda_sample;

  modport source (output valid, action, dev_addr, memory_address, write_data,
                  sda_sample, input ready);
  modport sink   (input valid, action, dev_addr, memory_address, write_data,
                  sda_sample, output ready);
endinterface : iebm_req_if

interface iebm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       retrying;

  modport source (output valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                  read_data, retrying, input ready);
  modport sink   (input valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                  read_data, retrying, output ready);
endinterface : iebm_res_if
`default_nettype wire

// ===== rtl/iebm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iebm_front
// Accepts request items, classifies the action and queues the commands.
// ----------------------------------------------------------------------------
module iebm_front (
  input  wire logic       clk,
  input  wire logic       rst,
  iebm_req_if.sink        req,
  output iebm_pkg::q_head_t head,
  input  wire logic       pop
);
  import iebm_pkg::*;

  cmd_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 push;
  cmd_t                 cmd_in;

  always_comb begin
    cmd_in.dev_addr       = req.dev_addr;
    cmd_in.memory_address = req.memory_address;
    cmd_in.write_data     = req.write_data;
    cmd_in.sda_sample     = req.sda_sample;
    case (req.action)
      ACT_TICK:  cmd_in.kind = CMD_TICK;
      ACT_WRITE: cmd_in.kind = CMD_WRITE;
      ACT_READ:  cmd_in.kind = CMD_READ;
      default:   cmd_in.kind = CMD_NOP;
    endcase
  end

  assign req.ready  = (count != Q_CNT_W'(Q_DEPTH));
  assign push       = req.valid && req.ready;
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule : iebm_front
`default_nettype wire

// ===== rtl/iebm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iebm_back
// Bus sequencer: runs one queued command per cycle while the result side is not stalled and registers the result.
// ----------------------------------------------------------------------------
module iebm_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [iebm_pkg::PHASE_W-1:0] cfg_wdata,
  input  wire iebm_pkg::q_head_t           head,
  output logic                             pop,
  iebm_res_if.source                       res
);
  import iebm_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE        = 23'h000001,
    S_CHK_HI      = 23'h000002,
    S_CHK_LO_BUSY = 23'h000004,
    S_CHK_LO_FREE = 23'h000008,
    S_STA_A       = 23'h000010,
    S_STA_B       = 23'h000020,
    S_STA_C       = 23'h000040,
    S_STA_D       = 23'h000080,
    S_BIT_SET     = 23'h000100,
    S_BIT_HI      = 23'h000200,
    S_BIT_LO      = 23'h000400,
    S_ACK_HI      = 23'h000800,
    S_ACK_LO_OK   = 23'h001000,
    S_ACK_LO_NAK  = 23'h002000,
    S_RD_HI       = 23'h004000,
    S_RD_LO       = 23'h008000,
    S_NK_SET      = 23'h010000,
    S_NK_HI       = 23'h020000,
    S_NK_LO       = 23'h040000,
    S_STO_A       = 23'h080000,
    S_STO_B       = 23'h100000,
    S_STO_C       = 23'h200000,
    S_STO_D       = 23'h400000
  } state_t;

  typedef enum logic [1:0] {
    STG_DEV  = 2'd0,
    STG_MEM  = 2'd1,
    STG_DATA = 2'd2
  } stage_t;

  function automatic pins_t enter_pins(state_t s, pins_t cur, logic msb);
    pins_t p;
    p = cur;
    case (s)
      S_CHK_HI, S_ACK_HI, S_RD_HI: begin
        p.scl = 1'b1;
        p.drv = 1'b0;
      end
      S_CHK_LO_BUSY, S_CHK_LO_FREE, S_ACK_LO_OK, S_ACK_LO_NAK, S_RD_LO: begin
        p.scl = 1'b0;
        p.drv = 1'b0;
      end
      S_STA_A, S_NK_SET, S_STO_C: begin
        p.drv = 1'b1;
        p.lvl = 1'b1;
      end
      S_STA_C, S_STO_A: begin
        p.drv = 1'b1;
        p.lvl = 1'b0;
      end
      S_STA_B, S_BIT_HI, S_NK_HI, S_STO_B, S_STO_D: p.scl = 1'b1;
      S_STA_D, S_BIT_LO, S_NK_LO:                   p.scl = 1'b0;
      S_BIT_SET: begin
        p.drv = 1'b1;
        p.lvl = msb;
      end
      default: p = cur;
    endcase
    return p;
  endfunction

  logic [PHASE_W-1:0] phase_ticks;
  logic [PHASE_W-1:0] phase_len;

  state_t             state, state_next, target;
  logic [PHASE_W-1:0] timer, timer_next;
  logic [3:0]         bit_count, bit_count_next;
  stage_t             stage, stage_next;
  logic               is_read, is_read_next;
  logic [7:0]         held_device, held_device_next;
  logic [7:0]         held_memory, held_memory_next;
  logic [7:0]         held_data, held_data_next;
  logic [7:0]         shift_reg, shift_reg_next;
  logic [7:0]         received_byte, received_byte_next;
  pins_t              pins, pins_next;
  logic               entered, start_byte, done, retry;
  logic               out_valid;
  cmd_t               cmd;

  assign cmd       = head.cmd;
  assign pop       = head.valid && (!out_valid || res.ready);
  assign phase_len = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;

  always_comb begin
    state_next         = state;
    timer_next         = timer;
    bit_count_next     = bit_count;
    stage_next         = stage;
    is_read_next       = is_read;
    held_device_next   = held_device;
    held_memory_next   = held_memory;
    held_data_next     = held_data;
    shift_reg_next     = shift_reg;
    received_byte_next = received_byte;
    pins_next          = pins;
    target             = state;
    entered            = 1'b0;
    start_byte         = 1'b0;
    done               = 1'b0;
    retry              = 1'b0;

    if (pop) begin
      case (cmd.kind)
        CMD_TICK: begin
          if (state != S_IDLE) begin
            if (timer > PHASE_W'(1)) begin
              timer_next = timer - 1'b1;
            end else begin
              timer_next = '0;
              entered    = 1'b1;
              case (state)
                S_CHK_HI:      target = cmd.sda_sample ? S_CHK_LO_FREE : S_CHK_LO_BUSY;
                S_CHK_LO_BUSY: target = S_CHK_HI;
                S_CHK_LO_FREE: begin
                  stage_next = STG_DEV;
                  target     = S_STA_A;
                end
                S_STA_A:       target = S_STA_B;
                S_STA_B:       target = S_STA_C;
                S_STA_C:       target = S_STA_D;
                S_STA_D:       start_byte = 1'b1;
                S_BIT_SET:     target = S_BIT_HI;
                S_BIT_HI:      target = S_BIT_LO;
                S_BIT_LO: begin
                  shift_reg_next = {shift_reg[6:0], 1'b0};
                  bit_count_next = bit_count + 1'b1;
                  target = (bit_count_next >= 4'd8) ? S_ACK_HI : S_BIT_SET;
                end
                S_ACK_HI:      target = cmd.sda_sample ? S_ACK_LO_NAK : S_ACK_LO_OK;
                S_ACK_LO_NAK: begin
                  retry  = 1'b1;
                  target = S_CHK_HI;
                end
                S_ACK_LO_OK: begin
                  if (stage == STG_DEV) begin
                    stage_next = STG_MEM;
                    start_byte = 1'b1;
                  end else if (stage == STG_MEM) begin
                    stage_next = STG_DATA;
                    if (is_read) begin
                      target = S_STA_A;
                    end else begin
                      start_byte = 1'b1;
                    end
                  end else if (is_read) begin
                    shift_reg_next = '0;
                    bit_count_next = '0;
                    target         = S_RD_HI;
                  end else begin
                    target = S_STO_A;
                  end
                end
                S_RD_HI: begin
                  shift_reg_next = {shift_reg[6:0], cmd.sda_sample};
                  target         = S_RD_LO;
                end
                S_RD_LO: begin
                  bit_count_next = bit_count + 1'b1;
                  if (bit_count_next >= 4'd8) begin
                    received_byte_next = shift_reg;
                    target             = S_NK_SET;
                  end else begin
                    target = S_RD_HI;
                  end
                end
                S_NK_SET:      target = S_NK_HI;
                S_NK_HI:       target = S_NK_LO;
                S_NK_LO:       target = S_STO_A;
                S_STO_A:       target = S_STO_B;
                S_STO_B:       target = S_STO_C;
                S_STO_C:       target = S_STO_D;
                S_STO_D: begin
                  entered    = 1'b0;
                  state_next = S_IDLE;
                  done       = 1'b1;
                end
                default: begin
                  entered    = 1'b0;
                  state_next = S_IDLE;
                end
              endcase
            end
          end
        end
        CMD_WRITE, CMD_READ: begin
          if (state == S_IDLE) begin
            held_device_next = cmd.dev_addr;
            held_memory_next = cmd.memory_address;
            held_data_next   = cmd.write_data;
            is_read_next     = (cmd.kind == CMD_READ);
            bit_count_next   = '0;
            stage_next       = STG_DEV;
            target           = S_CHK_HI;
            entered          = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (start_byte) begin
      case (stage_next)
        STG_DEV: shift_reg_next = held_device;
        STG_MEM: shift_reg_next = held_memory;
        default: shift_reg_next = is_read ? (held_device | 8'h01) : held_data;
      endcase
      bit_count_next = '0;
      target         = S_BIT_SET;
    end

    if (entered) begin
      state_next = target;
      timer_next = phase_len;
      pins_next  = enter_pins(target, pins, shift_reg_next[7]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_RESET;
    end else if (cfg_wen) begin
      phase_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      timer         <= '0;
      bit_count     <= '0;
      stage         <= STG_DEV;
      is_read       <= 1'b0;
      held_device   <= '0;
      held_memory   <= '0;
      held_data     <= '0;
      shift_reg     <= '0;
      received_byte <= '0;
      pins          <= '{scl: 1'b1, drv: 1'b0, lvl: 1'b1};
    end else begin
      state         <= state_next;
      timer         <= timer_next;
      bit_count     <= bit_count_next;
      stage         <= stage_next;
      is_read       <= is_read_next;
      held_device   <= held_device_next;
      held_memory   <= held_memory_next;
      held_data     <= held_data_next;
      shift_reg     <= shift_reg_next;
      received_byte <= received_byte_next;
      pins          <= pins_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.scl_level <= pins_next.scl;
      res.sda_drive <= pins_next.drv;
      res.sda_level <= pins_next.lvl;
      res.busy_res  <= (state_next != S_IDLE);
      res.done_res  <= done;
      res.read_data <= received_byte_next;
      res.retrying  <= retry;
    end
  end

  assign res.valid = out_valid;

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");

  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (timer == '0))
    else $error("phase timer running while idle");

  a_bit_count: assert property (@(posedge clk) disable iff (rst) bit_count <= 4'd8)
    else $error("bit count overran a byte");

  a_done_retry: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.done_res && res.retrying))
    else $error("stop completion and restart in the same result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.done_res) |-> !res.busy_res)
    else $error("done reported while still busy");

endmodule : iebm_back
`default_nettype wire

// ===== rtl/i2c_eeprom_byte_master.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// Bit-level I2C master for single-byte EEPROM writes and random reads.
// ----------------------------------------------------------------------------
// Each request item is one bus time unit (tick) or a write/read request; every
// item yields exactly one result carrying the pin levels, status and last read
// byte. One item is taken per clock while the queue has room: the front
// classifies items into a two-entry command queue, and the back sequencer
// consumes one command per cycle into a registered result unless the result
// side stalls; an accepted item passes through the queue and then the result
// register. The sequencer throughput is the limit at one item per cycle;
// ready falls only when the queue holds two commands because the result side
// is stalled. phase_ticks may be written only while no transfer is in flight.
module i2c_eeprom_byte_master (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wen,
  input  wire logic [iebm_pkg::PHASE_W-1:0] cfg_wdata,
  iebm_req_if.sink                          req,
  iebm_res_if.source                        res
);
  import iebm_pkg::*;

  q_head_t head;
  logic    pop;

  iebm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  iebm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .res       (res)
  );

endmodule : i2c_eeprom_byte_master
`default_nettype wire
